// File: sv/yfc_pkg.sv
// ----------------------------------------------------------------------------
// yfc_pkg: shared types and constants for the Young-Fibonacci chain builder
// Sizes, rank vector types, queue payload structs, back-end states and the
// one-hot bit helpers used by the scan logic.
// ----------------------------------------------------------------------------
package yfc_pkg;

  // permutation geometry
  localparam int PERM_LEN    = 16;
  localparam int VALUE_BITS  = 8;
  localparam int IN_VALUE_W  = 8;
  localparam int IDX_W       = $clog2(PERM_LEN);
  localparam int CNT_W       = $clog2(PERM_LEN + 1);

  // result fields
  localparam int LEVEL_W     = 5;
  localparam int WORD_W      = 51;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_W-1:0]      rank_t;
  typedef rank_t [PERM_LEN-1:0]  rank_vec_t;
  typedef logic [PERM_LEN-1:0]   pmask_t;
  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [LEVEL_W-1:0]    level_t;

  // decimal digits appended to a node word
  localparam word_t DIGIT_ONE = word_t'(1);
  localparam word_t DIGIT_TWO = word_t'(2);

  // fixed levels
  localparam level_t LEVEL_TOP  = level_t'(PERM_LEN);
  localparam level_t LEVEL_TWO  = level_t'(2);
  localparam level_t LEVEL_ONE  = level_t'(1);
  localparam level_t LEVEL_ZERO = level_t'(0);

  // front -> queue write side
  typedef struct packed {
    logic      push;
    rank_vec_t ranks;
  } q_wr_t;

  // queue -> back read side
  typedef struct packed {
    logic      valid;
    rank_vec_t ranks;
  } q_rd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN_Q,
    B_SCAN_P,
    B_EMIT,
    B_TAIL1,
    B_TAIL0
  } back_state_t;

  // lowest set bit as a one-hot mask
  function automatic pmask_t lsb_onehot(input pmask_t x);
    return x & (~x + pmask_t'(1));
  endfunction

  function automatic pmask_t bit_reverse(input pmask_t x);
    pmask_t r;
    for (int i = 0; i < PERM_LEN; i++) begin
      r[i] = x[PERM_LEN-1-i];
    end
    return r;
  endfunction

  // highest set bit as a one-hot mask
  function automatic pmask_t msb_onehot(input pmask_t x);
    return bit_reverse(lsb_onehot(bit_reverse(x)));
  endfunction

endpackage

// File: sv/yfc_if.sv
// ----------------------------------------------------------------------------
// yfc_if: valid/ready channel interfaces of the Young-Fibonacci chain builder
// yfc_in_if carries permutation entries, yfc_out_if carries chain nodes.
// ----------------------------------------------------------------------------
interface yfc_in_if;
  logic                            valid;
  logic                            ready;
  logic [yfc_pkg::IN_VALUE_W-1:0]  value;
  logic                            last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface yfc_out_if;
  logic                         valid;
  logic                         ready;
  logic [yfc_pkg::LEVEL_W-1:0]  level;
  logic [yfc_pkg::WORD_W-1:0]   q_word;
  logic [yfc_pkg::WORD_W-1:0]   p_word;
  logic                         final_res;

  modport source (output valid, output level, output q_word, output p_word,
                  output final_res, input ready);
  modport sink   (input valid, input level, input q_word, input p_word,
                  input final_res, output ready);
endinterface

// File: sv/yfc_front.sv
// ----------------------------------------------------------------------------
// yfc_front: permutation loader
// Stores entries by position and keeps a rank per position (0 = largest,
// ties go to the lower position), updated on every write. On the last item
// the rank vector is pushed to the job queue.
// ----------------------------------------------------------------------------
module yfc_front (
  input  logic           clk,
  input  logic           rst_n,
  yfc_in_if.sink         in_ch,
  output yfc_pkg::q_wr_t q_wr,
  input  logic           q_full
);

  logic [yfc_pkg::CNT_W-1:0] load_cnt_r, load_cnt_nxt;
  logic                      push_pending_r, push_pending_nxt;
  yfc_pkg::value_t           store_r [yfc_pkg::PERM_LEN];
  yfc_pkg::rank_vec_t        rank_r, rank_nxt;

  logic                      accept;
  logic                      room;
  logic                      wr_en;
  yfc_pkg::rank_t            wr_pos;
  yfc_pkg::value_t           new_val;
  yfc_pkg::value_t           old_val;
  yfc_pkg::pmask_t           beats_new;
  yfc_pkg::pmask_t           beats_old;
  yfc_pkg::pmask_t           ahead_of_new;
  yfc_pkg::rank_t            new_rank;

  // handshake and write decode
  assign in_ch.ready = !push_pending_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign room        = load_cnt_r < yfc_pkg::CNT_W'(yfc_pkg::PERM_LEN);
  assign wr_en       = accept && room;
  assign wr_pos      = load_cnt_r[yfc_pkg::IDX_W-1:0];
  assign new_val     = in_ch.value[yfc_pkg::VALUE_BITS-1:0];
  assign old_val     = store_r[wr_pos];

  // rank bookkeeping: per-position compares against the old and new entry
  always_comb begin
    for (int j = 0; j < yfc_pkg::PERM_LEN; j++) begin
      beats_new[j] = (new_val > store_r[j]) ||
                     ((new_val == store_r[j]) && (wr_pos < yfc_pkg::IDX_W'(j)));
      beats_old[j] = (old_val > store_r[j]) ||
                     ((old_val == store_r[j]) && (wr_pos < yfc_pkg::IDX_W'(j)));
      ahead_of_new[j] = (yfc_pkg::IDX_W'(j) != wr_pos) &&
                        ((store_r[j] > new_val) ||
                         ((store_r[j] == new_val) && (yfc_pkg::IDX_W'(j) < wr_pos)));
    end
    new_rank = yfc_pkg::IDX_W'($countones(ahead_of_new));
    for (int j = 0; j < yfc_pkg::PERM_LEN; j++) begin
      if (yfc_pkg::IDX_W'(j) == wr_pos) begin
        rank_nxt[j] = new_rank;
      end else begin
        rank_nxt[j] = rank_r[j] + yfc_pkg::rank_t'(beats_new[j])
                    - yfc_pkg::rank_t'(beats_old[j]);
      end
    end
  end

  // load count and job push
  always_comb begin
    load_cnt_nxt     = load_cnt_r;
    push_pending_nxt = push_pending_r;
    if (push_pending_r && !q_full) begin
      push_pending_nxt = 1'b0;
    end
    if (accept) begin
      if (in_ch.last) begin
        load_cnt_nxt     = '0;
        push_pending_nxt = 1'b1;
      end else if (room) begin
        load_cnt_nxt = load_cnt_r + yfc_pkg::CNT_W'(1);
      end
    end
  end

  assign q_wr.push  = push_pending_r && !q_full;
  assign q_wr.ranks = rank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r     <= '0;
      push_pending_r <= 1'b0;
    end else begin
      load_cnt_r     <= load_cnt_nxt;
      push_pending_r <= push_pending_nxt;
    end
  end

  // entry store and ranks; an all-zero store ranks each position by its index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < yfc_pkg::PERM_LEN; j++) begin
        store_r[j] <= '0;
        rank_r[j]  <= yfc_pkg::IDX_W'(j);
      end
    end else if (wr_en) begin
      store_r[wr_pos] <= new_val;
      rank_r          <= rank_nxt;
    end
  end

endmodule

// File: sv/yfc_queue.sv
// ----------------------------------------------------------------------------
// yfc_queue: short job queue between loader and chain engine
// Holds rank vectors of loaded permutations so the loader can take the next
// permutation while the engine is still emitting the previous one.
// ----------------------------------------------------------------------------
module yfc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  yfc_pkg::q_wr_t wr,
  output logic           full,
  output yfc_pkg::q_rd_t rd,
  input  logic           pop
);

  yfc_pkg::rank_vec_t         mem_r [yfc_pkg::QUEUE_DEPTH];
  logic [yfc_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [yfc_pkg::QCNT_W-1:0] cnt_r;
  logic                       do_wr, do_rd;

  function automatic logic [yfc_pkg::QPTR_W-1:0] ptr_inc(
    input logic [yfc_pkg::QPTR_W-1:0] p
  );
    if (p == yfc_pkg::QPTR_W'(yfc_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + yfc_pkg::QPTR_W'(1);
  endfunction

  assign full     = cnt_r == yfc_pkg::QCNT_W'(yfc_pkg::QUEUE_DEPTH);
  assign rd.valid = cnt_r != '0;
  assign rd.ranks = mem_r[rd_ptr_r];
  assign do_wr    = wr.push && !full;
  assign do_rd    = pop && rd.valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_rd) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + yfc_pkg::QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - yfc_pkg::QCNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr.ranks;
    end
  end

endmodule

// File: sv/yfc_back.sv
// ----------------------------------------------------------------------------
// yfc_back: chain engine
// Takes one job's ranks, then for each level builds the Q node and the P node
// one greedy step per cycle and emits them through an output register,
// followed by the fixed level 1 and level 0 results.
// ----------------------------------------------------------------------------
module yfc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  yfc_pkg::q_rd_t q_rd,
  output logic           q_pop,
  yfc_out_if.source      out_ch
);

  yfc_pkg::back_state_t state_r, state_nxt;
  // match_r[k] marks the position holding rank k
  yfc_pkg::pmask_t      match_r [yfc_pkg::PERM_LEN];
  yfc_pkg::pmask_t      match_nxt [yfc_pkg::PERM_LEN];
  yfc_pkg::level_t      level_r, level_nxt;
  yfc_pkg::pmask_t      p_rem_r, p_rem_nxt;
  yfc_pkg::pmask_t      q_rem_r, q_rem_nxt;
  yfc_pkg::pmask_t      scan_r, scan_nxt;
  yfc_pkg::word_t       acc_r, acc_nxt;
  logic                 first_r, first_nxt;
  yfc_pkg::pmask_t      p_pick_r, p_pick_nxt;
  yfc_pkg::word_t       q_word_r, q_word_nxt;
  yfc_pkg::word_t       p_word_r, p_word_nxt;

  logic                 out_valid_r, out_valid_nxt;
  yfc_pkg::level_t      out_level_r, out_level_nxt;
  yfc_pkg::word_t       out_q_r, out_q_nxt;
  yfc_pkg::word_t       out_p_r, out_p_nxt;
  logic                 out_final_r, out_final_nxt;

  yfc_pkg::pmask_t      r_vec, r_low, sel, max_oh, rest, above, hi_oh, scan_step;
  logic                 has2, step_done, out_free;
  yfc_pkg::word_t       acc_step;
  yfc_pkg::level_t      lvl_m1;
  yfc_pkg::pmask_t      q_rem_upd;

  // one greedy step: take the largest present, then the rightmost beyond it
  always_comb begin
    for (int k = 0; k < yfc_pkg::PERM_LEN; k++) begin
      r_vec[k] = |(scan_r & match_r[k]);
    end
    r_low = yfc_pkg::lsb_onehot(r_vec);
    sel   = '0;
    for (int k = 0; k < yfc_pkg::PERM_LEN; k++) begin
      if (r_low[k]) begin
        sel = sel | match_r[k];
      end
    end
    max_oh    = scan_r & sel;
    rest      = scan_r & ~max_oh;
    above     = ~(max_oh | (max_oh - yfc_pkg::pmask_t'(1)));
    has2      = |(rest & above);
    hi_oh     = yfc_pkg::msb_onehot(rest);
    scan_step = has2 ? (rest & ~hi_oh) : rest;
    acc_step  = (acc_r << 3) + (acc_r << 1)
              + (has2 ? yfc_pkg::DIGIT_TWO : yfc_pkg::DIGIT_ONE);
    step_done = scan_step == '0;
  end

  assign out_free  = !out_valid_r || out_ch.ready;
  assign lvl_m1    = level_r - yfc_pkg::LEVEL_ONE;
  assign q_rem_upd = q_rem_r | (yfc_pkg::pmask_t'(1) << lvl_m1[yfc_pkg::IDX_W-1:0]);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    match_nxt     = match_r;
    level_nxt     = level_r;
    p_rem_nxt     = p_rem_r;
    q_rem_nxt     = q_rem_r;
    scan_nxt      = scan_r;
    acc_nxt       = acc_r;
    first_nxt     = first_r;
    p_pick_nxt    = p_pick_r;
    q_word_nxt    = q_word_r;
    p_word_nxt    = p_word_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_level_nxt = out_level_r;
    out_q_nxt     = out_q_r;
    out_p_nxt     = out_p_r;
    out_final_nxt = out_final_r;
    q_pop         = 1'b0;

    case (state_r)
      yfc_pkg::B_IDLE: begin
        if (q_rd.valid) begin
          q_pop = 1'b1;
          for (int k = 0; k < yfc_pkg::PERM_LEN; k++) begin
            for (int i = 0; i < yfc_pkg::PERM_LEN; i++) begin
              match_nxt[k][i] = q_rd.ranks[i] == yfc_pkg::IDX_W'(k);
            end
          end
          level_nxt = yfc_pkg::LEVEL_TOP;
          p_rem_nxt = '0;
          q_rem_nxt = '0;
          scan_nxt  = '1;
          acc_nxt   = '0;
          state_nxt = yfc_pkg::B_SCAN_Q;
        end
      end

      yfc_pkg::B_SCAN_Q: begin
        scan_nxt = scan_step;
        acc_nxt  = acc_step;
        if (step_done) begin
          q_word_nxt = acc_step;
          scan_nxt   = ~p_rem_r;
          acc_nxt    = '0;
          first_nxt  = 1'b1;
          state_nxt  = yfc_pkg::B_SCAN_P;
        end
      end

      yfc_pkg::B_SCAN_P: begin
        scan_nxt  = scan_step;
        acc_nxt   = acc_step;
        first_nxt = 1'b0;
        // the first pick of the P scan is the entry this chain drops next
        if (first_r) begin
          p_pick_nxt = max_oh;
        end
        if (step_done) begin
          p_word_nxt = acc_step;
          state_nxt  = yfc_pkg::B_EMIT;
        end
      end

      yfc_pkg::B_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = level_r;
          out_q_nxt     = q_word_r;
          out_p_nxt     = p_word_r;
          out_final_nxt = 1'b0;
          p_rem_nxt     = p_rem_r | p_pick_r;
          q_rem_nxt     = q_rem_upd;
          level_nxt     = lvl_m1;
          if (level_r == yfc_pkg::LEVEL_TWO) begin
            state_nxt = yfc_pkg::B_TAIL1;
          end else begin
            scan_nxt  = ~q_rem_upd;
            acc_nxt   = '0;
            state_nxt = yfc_pkg::B_SCAN_Q;
          end
        end
      end

      yfc_pkg::B_TAIL1: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = yfc_pkg::LEVEL_ONE;
          out_q_nxt     = yfc_pkg::DIGIT_ONE;
          out_p_nxt     = yfc_pkg::DIGIT_ONE;
          out_final_nxt = 1'b0;
          state_nxt     = yfc_pkg::B_TAIL0;
        end
      end

      yfc_pkg::B_TAIL0: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = yfc_pkg::LEVEL_ZERO;
          out_q_nxt     = '0;
          out_p_nxt     = '0;
          out_final_nxt = 1'b1;
          state_nxt     = yfc_pkg::B_IDLE;
        end
      end

      default: begin
        state_nxt = yfc_pkg::B_IDLE;
      end
    endcase
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.level     = out_level_r;
  assign out_ch.q_word    = out_q_r;
  assign out_ch.p_word    = out_p_r;
  assign out_ch.final_res = out_final_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= yfc_pkg::B_IDLE;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    match_r     <= match_nxt;
    level_r     <= level_nxt;
    p_rem_r     <= p_rem_nxt;
    q_rem_r     <= q_rem_nxt;
    scan_r      <= scan_nxt;
    acc_r       <= acc_nxt;
    p_pick_r    <= p_pick_nxt;
    q_word_r    <= q_word_nxt;
    p_word_r    <= p_word_nxt;
    out_level_r <= out_level_nxt;
    out_q_r     <= out_q_nxt;
    out_p_r     <= out_p_nxt;
    out_final_r <= out_final_nxt;
  end

endmodule

// File: sv/young_fibonacci_chain_builder_top.sv
// ----------------------------------------------------------------------------
// young_fibonacci_chain_builder_top: Young-Fibonacci chain builder
// Loads a 16-entry permutation and emits its P and Q chain nodes per level.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one permutation entry per item, position 0 first; last marks the
//            final entry and starts a run. Entries past the sixteenth are
//            dropped. One item per cycle while no job waits for the queue.
//   out_ch : 17 items per run, level 16 down to 0, each with the Q and P node
//            packed as decimal digits; final_res marks level 0.
// Operation:
//   The loader stores the entries and hands the job to the engine through
//   the queue; it then takes the next permutation while the engine runs.
//   The engine builds each level's Q node and then its P node at one digit
//   per cycle, using the single greedy step unit for both, and then emits
//   the level through the output register.
// Reset: rst_n (synchronous, active low) empties the queue, idles the
//   engine and clears the stored entries to zero.
// Stall: a stalled out_ch holds its item in the output register; the engine
//   finishes the next level and waits; the loader stalls while handing a job
//   to the queue, until under two jobs are queued behind the running one.
// ----------------------------------------------------------------------------
module young_fibonacci_chain_builder_top (
  input  logic      clk,
  input  logic      rst_n,
  yfc_in_if.sink    in_ch,
  yfc_out_if.source out_ch
);

  yfc_pkg::q_wr_t q_wr;
  yfc_pkg::q_rd_t q_rd;
  logic           q_full;
  logic           q_pop;

  yfc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_wr   (q_wr),
    .q_full (q_full)
  );

  yfc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .full  (q_full),
    .rd    (q_rd),
    .pop   (q_pop)
  );

  yfc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

// File: tb/young_fibonacci_chain_builder_top_test.sv
// ----------------------------------------------------------------------------
// young_fibonacci_chain_builder_top_test: self-checking bench for the chain builder
// Loads permutations through in_ch and checks every chain node on out_ch
// against a greedy node builder kept in a small scoreboard. Covers well-formed
// permutations, equal values, entries past the sixteenth and an early last
// flag, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module young_fibonacci_chain_builder_top_test;

  localparam int RADIX         = 10;
  localparam int ITEM_TARGET   = 420;
  localparam int CALM_ITEMS    = 60;
  localparam int SETTLE_CYCLES = 400;
  localparam int MAX_BURST     = 17;

  typedef enum int {RUN_PERM, RUN_DUPES, RUN_OVERFLOW, RUN_EARLY} run_kind_t;

  // one chain node as seen on out_ch
  typedef struct {
    yfc_pkg::level_t level;
    yfc_pkg::word_t  q_word;
    yfc_pkg::word_t  p_word;
    logic            final_res;
  } node_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps the loaded entries and the nodes still to come
  // --------------------------------------------------------------------------
  class chain_scoreboard;
    yfc_pkg::value_t store [yfc_pkg::PERM_LEN];
    int unsigned     load_cnt;
    node_t           expected_nodes[$];
    int              errors;

    function new();
      load_cnt = 0;
      errors   = 0;
    endfunction

    // position of the largest present value, lowest position on ties
    function int largest_pos(yfc_pkg::pmask_t present);
      int best;
      int best_val;
      best     = 0;
      best_val = -1;
      for (int i = 0; i < yfc_pkg::PERM_LEN; i++) begin
        if (present[i] && int'(store[i]) > best_val) begin
          best_val = int'(store[i]);
          best     = i;
        end
      end
      return best;
    endfunction

    // greedy word over the positions not yet removed
    function yfc_pkg::word_t greedy_word(yfc_pkg::pmask_t removed);
      yfc_pkg::pmask_t left;
      int              idx;
      int              hi;
      yfc_pkg::word_t  w;
      left = ~removed;
      w    = '0;
      while (left != '0) begin
        idx       = largest_pos(left);
        left[idx] = 1'b0;
        if ((left >> idx) != '0) begin
          hi = yfc_pkg::PERM_LEN - 1;
          while (!left[hi]) hi--;
          left[hi] = 1'b0;
          w = yfc_pkg::word_t'(w * RADIX + yfc_pkg::DIGIT_TWO);
        end else begin
          w = yfc_pkg::word_t'(w * RADIX + yfc_pkg::DIGIT_ONE);
        end
      end
      return w;
    endfunction

    // accepted input item; a last flag queues the whole chain
    function void note_entry(yfc_pkg::value_t v, bit is_last);
      yfc_pkg::pmask_t q_gone;
      yfc_pkg::pmask_t p_gone;
      if (load_cnt < yfc_pkg::PERM_LEN) begin
        store[load_cnt] = v;
        load_cnt++;
      end
      if (!is_last) return;
      q_gone = '0;
      p_gone = '0;
      for (int lvl = yfc_pkg::PERM_LEN; lvl >= 2; lvl--) begin
        expected_nodes.push_back(node_t'{yfc_pkg::level_t'(lvl), greedy_word(q_gone),
                                         greedy_word(p_gone), 1'b0});
        p_gone[largest_pos(~p_gone)] = 1'b1;
        q_gone[lvl-1]                = 1'b1;
      end
      expected_nodes.push_back(node_t'{yfc_pkg::LEVEL_ONE, yfc_pkg::DIGIT_ONE,
                                       yfc_pkg::DIGIT_ONE, 1'b0});
      expected_nodes.push_back(node_t'{yfc_pkg::LEVEL_ZERO, '0, '0, 1'b1});
      load_cnt = 0;
    endfunction

    // accepted result item against the oldest expected node
    function void check_node(node_t got);
      node_t want;
      if (expected_nodes.size() == 0) begin
        $display("%0t: unexpected node: level %0d q %0d p %0d final %0b", $time,
                 got.level, got.q_word, got.p_word, got.final_res);
        errors++;
        return;
      end
      want = expected_nodes.pop_front();
      if (got.level !== want.level) begin
        $display("%0t: level: expected %0d, actual %0d", $time, want.level, got.level);
        errors++;
      end
      if (got.q_word !== want.q_word) begin
        $display("%0t: q_word (level %0d): expected %0d, actual %0d", $time,
                 want.level, want.q_word, got.q_word);
        errors++;
      end
      if (got.p_word !== want.p_word) begin
        $display("%0t: p_word (level %0d): expected %0d, actual %0d", $time,
                 want.level, want.p_word, got.p_word);
        errors++;
      end
      if (got.final_res !== want.final_res) begin
        $display("%0t: final_res (level %0d): expected %0b, actual %0b", $time,
                 want.level, want.final_res, got.final_res);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   items_sent;
  int   gap_pct;

  chain_scoreboard board = new();

  yfc_in_if  in_ch ();
  yfc_out_if out_ch ();

  young_fibonacci_chain_builder_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("** young_fibonacci_chain_builder_top: FAILED **");
    $finish;
  end

  // sink side: ready with random stall bursts, stall rate changes now and then
  initial begin
    int stall_pct;
    int span;
    out_ch.ready <= 1'b0;
    stall_pct = 0;
    span      = 0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        stall_pct = $urandom_range(0, 2) * 15;
        span      = $urandom_range(20, 120);
      end
      span--;
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_node(node_t'{out_ch.level, out_ch.q_word, out_ch.p_word,
                               out_ch.final_res});
  end

  // one permutation entry; an optional idle burst goes first
  task automatic push_entry(yfc_pkg::value_t v, bit is_last);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_entry(v, is_last);
    items_sent++;
    calm = (items_sent >= ITEM_TARGET - CALM_ITEMS);
  endtask

  // main sequence
  initial begin
    yfc_pkg::value_t entries[$];
    yfc_pkg::value_t v;
    bit              used [256];
    run_kind_t       kind;
    int              lo;

    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.last  <= 1'b0;
    rst_n       <= 1'b0;
    calm       = 1'b0;
    items_sent = 0;
    gap_pct    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full permutation holding both extremes, alternating and nibble patterns and single-bit values
    entries = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h33, 8'hCC,
                8'h01, 8'h80, 8'h7F, 8'hFE, 8'h10, 8'h20, 8'h40, 8'h08};
    foreach (entries[i]) push_entry(entries[i], i == entries.size() - 1);

    // directed: early last over the leftover store, two equal maxima
    entries = '{8'hFF, 8'h02, 8'hFF};
    foreach (entries[i]) push_entry(entries[i], i == entries.size() - 1);

    // random runs, mostly well-formed permutations
    for (int run_no = 0; items_sent < ITEM_TARGET; run_no++) begin
      entries.delete();
      used    = '{default: 1'b0};
      gap_pct = $urandom_range(0, 2) * 12;
      case (run_no % 8)
        5:       kind = RUN_DUPES;
        6:       kind = RUN_OVERFLOW;
        7:       kind = RUN_EARLY;
        default: kind = RUN_PERM;
      endcase
      case (kind)
        RUN_DUPES: begin
          lo = $urandom_range(0, 250);
          repeat (yfc_pkg::PERM_LEN)
            entries.push_back(yfc_pkg::value_t'($urandom_range(lo, lo + 5)));
        end
        RUN_EARLY: begin
          repeat ($urandom_range(1, yfc_pkg::PERM_LEN - 1))
            entries.push_back(yfc_pkg::value_t'($urandom));
        end
        default: begin
          while (entries.size() < yfc_pkg::PERM_LEN) begin
            v = yfc_pkg::value_t'($urandom);
            if (!used[v]) begin
              used[v] = 1'b1;
              entries.push_back(v);
            end
          end
          // entries past the sixteenth are dropped by the loader
          if (kind == RUN_OVERFLOW)
            repeat ($urandom_range(1, 4)) entries.push_back(yfc_pkg::value_t'($urandom));
        end
      endcase
      foreach (entries[i]) push_entry(entries[i], i == entries.size() - 1);
    end
    in_ch.valid <= 1'b0;

    // drain, then give the block time to show any stray item
    while (board.expected_nodes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.expected_nodes.size() != 0) begin
      $display("%0t: %0d nodes never arrived", $time, board.expected_nodes.size());
      board.errors++;
    end

    if (board.errors == 0) begin
      $display("** young_fibonacci_chain_builder_top: PASSED **");
    end else begin
      $display("** young_fibonacci_chain_builder_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: young_fibonacci_chain_builder_top.f
sv/yfc_pkg.sv
sv/yfc_if.sv
sv/yfc_front.sv
sv/yfc_queue.sv
sv/yfc_back.sv
sv/young_fibonacci_chain_builder_top.sv
tb/young_fibonacci_chain_builder_top_test.sv
